// File: hdl/mcd_pkg.sv
package mcd_pkg;

    // input character codes
    localparam logic [7:0] C_IN_DOT     = 8'h2E;
    localparam logic [7:0] C_IN_DASH    = 8'h2D;
    localparam logic [7:0] C_IN_SPACE   = 8'h20;
    localparam logic [7:0] C_IN_NEWLINE = 8'h0A;

    // output character codes
    localparam logic [6:0] C_OUT_NONE    = 7'h00;
    localparam logic [6:0] C_OUT_SPACE   = 7'h20;
    localparam logic [6:0] C_OUT_NEWLINE = 7'h0A;

    localparam int SYM_BITS_W = 6;
    localparam int SYM_LEN_W  = 3;

    // results of one request, at most two
    typedef struct packed {
        logic [1:0] num;
        logic [6:0] ch0;
        logic [6:0] ch1;
    } t_step_res;

    // code table: length and element pattern (dash = 1, first element highest)
    function automatic logic [6:0] f_lookup(input logic [SYM_LEN_W-1:0]  len,
                                            input logic [SYM_BITS_W-1:0] bits);
        logic [6:0] ch;
        ch = C_OUT_NONE;
        unique case ({len, bits})
            {3'd1, 6'd0}:  ch = 7'h45; // E
            {3'd1, 6'd1}:  ch = 7'h54; // T
            {3'd2, 6'd0}:  ch = 7'h49; // I
            {3'd2, 6'd1}:  ch = 7'h41; // A
            {3'd2, 6'd2}:  ch = 7'h4E; // N
            {3'd2, 6'd3}:  ch = 7'h4D; // M
            {3'd3, 6'd0}:  ch = 7'h53; // S
            {3'd3, 6'd1}:  ch = 7'h55; // U
            {3'd3, 6'd2}:  ch = 7'h52; // R
            {3'd3, 6'd3}:  ch = 7'h57; // W
            {3'd3, 6'd4}:  ch = 7'h44; // D
            {3'd3, 6'd5}:  ch = 7'h4B; // K
            {3'd3, 6'd6}:  ch = 7'h47; // G
            {3'd3, 6'd7}:  ch = 7'h4F; // O
            {3'd4, 6'd0}:  ch = 7'h48; // H
            {3'd4, 6'd1}:  ch = 7'h56; // V
            {3'd4, 6'd2}:  ch = 7'h46; // F
            {3'd4, 6'd4}:  ch = 7'h4C; // L
            {3'd4, 6'd6}:  ch = 7'h50; // P
            {3'd4, 6'd7}:  ch = 7'h4A; // J
            {3'd4, 6'd8}:  ch = 7'h42; // B
            {3'd4, 6'd9}:  ch = 7'h58; // X
            {3'd4, 6'd10}: ch = 7'h43; // C
            {3'd4, 6'd11}: ch = 7'h59; // Y
            {3'd4, 6'd12}: ch = 7'h5A; // Z
            {3'd4, 6'd13}: ch = 7'h51; // Q
            {3'd5, 6'd0}:  ch = 7'h35; // 5
            {3'd5, 6'd1}:  ch = 7'h34; // 4
            {3'd5, 6'd3}:  ch = 7'h33; // 3
            {3'd5, 6'd7}:  ch = 7'h32; // 2
            {3'd5, 6'd8}:  ch = 7'h26; // &
            {3'd5, 6'd10}: ch = 7'h2B; // +
            {3'd5, 6'd15}: ch = 7'h31; // 1
            {3'd5, 6'd16}: ch = 7'h36; // 6
            {3'd5, 6'd17}: ch = 7'h3D; // =
            {3'd5, 6'd18}: ch = 7'h2F; // /
            {3'd5, 6'd22}: ch = 7'h28; // (
            {3'd5, 6'd24}: ch = 7'h37; // 7
            {3'd5, 6'd28}: ch = 7'h38; // 8
            {3'd5, 6'd30}: ch = 7'h39; // 9
            {3'd5, 6'd31}: ch = 7'h30; // 0
            {3'd6, 6'd12}: ch = 7'h3F; // ?
            {3'd6, 6'd13}: ch = 7'h5F; // _
            {3'd6, 6'd18}: ch = 7'h22; // double quote
            {3'd6, 6'd21}: ch = 7'h2E; // full stop
            {3'd6, 6'd26}: ch = 7'h40; // @
            {3'd6, 6'd30}: ch = 7'h27; // apostrophe
            {3'd6, 6'd33}: ch = 7'h2D; // -
            {3'd6, 6'd42}: ch = 7'h3B; // ;
            {3'd6, 6'd43}: ch = 7'h21; // !
            {3'd6, 6'd45}: ch = 7'h29; // )
            {3'd6, 6'd51}: ch = 7'h2C; // comma
            {3'd6, 6'd56}: ch = 7'h3A; // :
            default:       ch = C_OUT_NONE;
        endcase
        return ch;
    endfunction

endpackage

// File: hdl/mcd_step.sv
module mcd_step #(
    parameter int MAX_SYMBOL_LEN = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [7:0]           i_char,
    output mcd_pkg::t_step_res   o_res
);

    localparam logic [1:0] SR_NONE = 2'd0;
    localparam logic [1:0] SR_ONE  = 2'd1;
    localparam logic [1:0] SR_WORD = 2'd2;

    logic [mcd_pkg::SYM_BITS_W-1:0] r_bits, n_bits;
    logic [mcd_pkg::SYM_LEN_W-1:0]  r_len, n_len;
    logic                           r_inv, n_inv;
    logic [1:0]                     r_space, n_space;
    logic                           r_started, n_started;
    logic [6:0]                     sym_ch;

    assign sym_ch = (r_inv || r_len == '0) ? mcd_pkg::C_OUT_NONE
                                            : mcd_pkg::f_lookup(r_len, r_bits);

    always_comb begin
        n_bits    = r_bits;
        n_len     = r_len;
        n_inv     = r_inv;
        n_space   = r_space;
        n_started = r_started;
        o_res     = '0;
        unique case (i_char) inside
            mcd_pkg::C_IN_DOT, mcd_pkg::C_IN_DASH: begin
                if (r_len >= mcd_pkg::SYM_LEN_W'(MAX_SYMBOL_LEN)) begin
                    n_inv = 1'b1;
                end else begin
                    n_bits = {r_bits[mcd_pkg::SYM_BITS_W-2:0], i_char == mcd_pkg::C_IN_DASH};
                    n_len  = r_len + 1'b1;
                end
                n_space = SR_NONE;
            end
            mcd_pkg::C_IN_SPACE: begin
                if (r_space == SR_NONE) begin
                    if (sym_ch != mcd_pkg::C_OUT_NONE) begin
                        o_res.num = 2'd1;
                        o_res.ch0 = sym_ch;
                        n_started = 1'b1;
                    end
                    n_bits  = '0;
                    n_len   = '0;
                    n_inv   = 1'b0;
                    n_space = SR_ONE;
                end else if (r_space == SR_ONE && r_started) begin
                    o_res.num = 2'd1;
                    o_res.ch0 = mcd_pkg::C_OUT_SPACE;
                    n_space   = SR_WORD;
                end
            end
            mcd_pkg::C_IN_NEWLINE: begin
                if (r_space == SR_NONE && sym_ch != mcd_pkg::C_OUT_NONE) begin
                    o_res.num = 2'd2;
                    o_res.ch0 = sym_ch;
                    o_res.ch1 = mcd_pkg::C_OUT_NEWLINE;
                end else begin
                    o_res.num = 2'd1;
                    o_res.ch0 = mcd_pkg::C_OUT_NEWLINE;
                end
                n_bits    = '0;
                n_len     = '0;
                n_inv     = 1'b0;
                n_space   = SR_NONE;
                n_started = 1'b0;
            end
            default: begin
                n_inv   = 1'b1;
                n_space = SR_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits    <= '0;
            r_len     <= '0;
            r_inv     <= 1'b0;
            r_space   <= SR_NONE;
            r_started <= 1'b0;
        end else if (i_fire) begin
            r_bits    <= n_bits;
            r_len     <= n_len;
            r_inv     <= n_inv;
            r_space   <= n_space;
            r_started <= n_started;
        end
    end

endmodule

// File: hdl/mcd_outbuf.sv
module mcd_outbuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  mcd_pkg::t_step_res i_res,
    output logic               o_can_load,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [6:0]         o_char,
    output logic               o_last
);

    logic [1:0] r_cnt, n_cnt;
    logic [6:0] r_ch0, n_ch0;
    logic [6:0] r_ch1, n_ch1;
    logic       pop;

    assign pop        = (r_cnt != 2'd0) && i_ready;
    assign o_can_load = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);
    assign o_valid    = r_cnt != 2'd0;
    assign o_char     = r_ch0;
    // the buffer only ever holds the results of one request
    assign o_last     = r_cnt == 2'd1;

    always_comb begin
        n_cnt = r_cnt;
        n_ch0 = r_ch0;
        n_ch1 = r_ch1;
        if (i_load) begin
            n_cnt = i_res.num;
            n_ch0 = i_res.ch0;
            n_ch1 = i_res.ch1;
        end else if (pop) begin
            n_cnt = r_cnt - 1'b1;
            n_ch0 = r_ch1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch0 <= n_ch0;
        r_ch1 <= n_ch1;
    end

endmodule

// File: hdl/morse_code_decoder.sv
// morse code decoder: one ascii character per request in, decoded characters out
//
// input channel (i_in_valid / o_in_ready / i_in_char): '.', '-', space, newline;
//   any other byte marks the pending symbol invalid
// output channel (o_out_valid / i_out_ready / o_out_char / o_out_last): one
//   decoded character per transfer; o_out_last flags the final result of an
//   input request (a newline may give two results: a character, then 10)
// a request passes the input register, then decode and table lookup into the
//   result register
// the block takes one request per cycle while each gives at most one result and the
//   receiver is ready; a request giving two results holds the result register until
//   both are taken, which is set by the single output port of the result register
// a request giving no result passes the decode stage without waiting on the
//   output side
// reset (synchronous, active low) clears the symbol, the space count, the
//   message state and both registers' valid flags
// receiver stall: results wait in the result register; requests giving no
//   result still pass, and the first request with a result waits in the input
//   register, which drops o_in_ready
module morse_code_decoder #(
    parameter int MAX_SYMBOL_LEN = 6
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_char,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [6:0] o_out_char,
    output logic       o_out_last
);

    // input register
    logic       r_in_vld;
    logic [7:0] r_in_char;

    mcd_pkg::t_step_res step_res;
    logic               buf_can_load;
    logic               fire;

    // decode stage moves on when its results fit, or when it has none
    assign fire       = r_in_vld && (step_res.num == 2'd0 || buf_can_load);
    assign o_in_ready = !r_in_vld || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_char <= i_in_char;
        end
    end

    // symbol state and table lookup
    mcd_step #(
        .MAX_SYMBOL_LEN (MAX_SYMBOL_LEN)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_char  (r_in_char),
        .o_res   (step_res)
    );

    // result register
    mcd_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire && step_res.num != 2'd0),
        .i_res      (step_res),
        .o_can_load (buf_can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_char     (o_out_char),
        .o_last     (o_out_last)
    );

endmodule

// File: hdl/mcd_checker.sv
module mcd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [6:0] o_out_char,
    input logic       o_out_last
);

    // nothing pending straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("results or stall after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_char) && $stable(o_out_last))
        else $error("stalled result changed");

    // a newline always ends the results of its request
    a_newline_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_char == mcd_pkg::C_OUT_NEWLINE |-> o_out_last)
        else $error("newline not flagged last");

    // a non-final result is always followed at once by the newline
    a_pair_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_last |=>
            o_out_valid && o_out_char == mcd_pkg::C_OUT_NEWLINE)
        else $error("second result missing or not a newline");

endmodule

bind morse_code_decoder mcd_checker u_mcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_char  (o_out_char),
    .o_out_last  (o_out_last)
);

// File: verif/mcd_checker.sv
`timescale 1ns / 100ps

module mcd_tb_checker #(
    parameter int MAX_SYMBOL_LEN = 6
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic       i_req_ready,
    input  logic [7:0] i_req_char,
    input  logic       i_res_valid,
    input  logic       i_res_ready,
    input  logic [6:0] i_res_char,
    input  logic       i_res_last,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } t_decoded;

    // code table, keys in the same order as the characters
    string code_keys = {".- -... -.-. -.. . ..-. --. .... .. .--- -.- .-.. -- -. --- ",
                        ".--. --.- .-. ... - ..- ...- .-- -..- -.-- --.. ----- .---- ",
                        "..--- ...-- ....- ..... -.... --... ---.. ----. .-.-.- ",
                        "--..-- ..--.. .----. -.-.-- -..-. -.--. -.--.- .-... ---... ",
                        "-.-.-. -...- .-.-. -....- ..--.- .-..-. .--.-."};
    string code_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.,?'!/()&:;=+-_\"@";

    logic [5:0] sym_pattern;
    logic [2:0] sym_count;
    logic       sym_bad;
    logic [1:0] space_count;
    logic       msg_started;

    t_decoded   pending_chars[$];

    initial o_fail_count = 0;
    initial o_pending = 0;

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        o_fail_count++;
    endtask

    function automatic logic [6:0] code_table_char(input logic [2:0] len,
                                                   input logic [5:0] pat);
        int         k;
        int         n;
        logic [5:0] acc;
        logic [6:0] ch;
        logic [7:0] b;
        k   = 0;
        n   = 0;
        acc = '0;
        ch  = mcd_pkg::C_OUT_NONE;
        for (int i = 0; i <= code_keys.len(); i++) begin
            if (i == code_keys.len() || code_keys[i] == mcd_pkg::C_IN_SPACE) begin
                if (n != 0) begin
                    if (n == len && acc == pat && ch == mcd_pkg::C_OUT_NONE) begin
                        b  = code_chars[k];
                        ch = b[6:0];
                    end
                    k++;
                end
                n   = 0;
                acc = '0;
            end else begin
                acc = {acc[4:0], code_keys[i] == mcd_pkg::C_IN_DASH};
                n++;
            end
        end
        return ch;
    endfunction

    function automatic logic [6:0] pending_symbol_char();
        if (sym_bad)
            return mcd_pkg::C_OUT_NONE;
        return code_table_char(sym_count, sym_pattern);
    endfunction

    task automatic clear_symbol();
        sym_pattern = '0;
        sym_count   = '0;
        sym_bad     = 1'b0;
    endtask

    task automatic decode_request(input logic [7:0] c);
        logic [6:0] res [2];
        logic [6:0] d;
        t_decoded   e;
        int         n;
        n = 0;
        if (c == mcd_pkg::C_IN_DOT || c == mcd_pkg::C_IN_DASH) begin
            if (sym_count >= MAX_SYMBOL_LEN) begin
                sym_bad = 1'b1;
            end else begin
                sym_pattern = {sym_pattern[4:0], c == mcd_pkg::C_IN_DASH};
                sym_count   = sym_count + 3'd1;
            end
            space_count = 2'd0;
        end else if (c == mcd_pkg::C_IN_SPACE) begin
            if (space_count == 2'd0) begin
                d = pending_symbol_char();
                if (d != mcd_pkg::C_OUT_NONE) begin
                    res[n] = d;
                    n++;
                    msg_started = 1'b1;
                end
                clear_symbol();
                space_count = 2'd1;
            end else if (space_count == 2'd1 && msg_started) begin
                res[n] = mcd_pkg::C_OUT_SPACE;
                n++;
                space_count = 2'd2;
            end
        end else if (c == mcd_pkg::C_IN_NEWLINE) begin
            if (space_count == 2'd0) begin
                d = pending_symbol_char();
                if (d != mcd_pkg::C_OUT_NONE) begin
                    res[n] = d;
                    n++;
                end
            end
            res[n] = mcd_pkg::C_OUT_NEWLINE;
            n++;
            clear_symbol();
            space_count = 2'd0;
            msg_started = 1'b0;
        end else begin
            sym_bad     = 1'b1;
            space_count = 2'd0;
        end
        for (int i = 0; i < n; i++) begin
            e.ch   = res[i];
            e.last = (i == n - 1);
            pending_chars.push_back(e);
        end
    endtask

    always @(posedge i_clk) begin
        t_decoded e;
        if (!i_rst_n) begin
            clear_symbol();
            space_count = 2'd0;
            msg_started = 1'b0;
            pending_chars.delete();
        end else begin
            if (i_req_valid && i_req_ready)
                decode_request(i_req_char);
            if (i_res_valid && i_res_ready) begin
                if (pending_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected result char %h last %b",
                                              i_res_char, i_res_last));
                end else begin
                    e = pending_chars.pop_front();
                    if (i_res_char !== e.ch)
                        report_mismatch($sformatf("char %h, expected %h",
                                                  i_res_char, e.ch));
                    if (i_res_last !== e.last)
                        report_mismatch($sformatf("last %b, expected %b (char %h)",
                                                  i_res_last, e.last, e.ch));
                end
            end
        end
        o_pending = pending_chars.size();
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int SYM_MAX = 6;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_in_char;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [6:0] o_out_char;
    logic       o_out_last;

    int         n_fail;
    int         n_pending;
    int         n_sent;

    // idling percentages of the current phase
    int         send_idle_pct;
    int         recv_stall_pct;

    morse_code_decoder #(
        .MAX_SYMBOL_LEN(SYM_MAX)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_char  (i_in_char),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_char (o_out_char),
        .o_out_last (o_out_last)
    );

    // watches both channels, predicts the decoded stream and compares
    mcd_tb_checker #(
        .MAX_SYMBOL_LEN(SYM_MAX)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .i_req_ready (o_in_ready),
        .i_req_char  (i_in_char),
        .i_res_valid (o_out_valid),
        .i_res_ready (i_out_ready),
        .i_res_char  (o_out_char),
        .i_res_last  (o_out_last),
        .o_fail_count(n_fail),
        .o_pending   (n_pending)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // receiver back-pressure, redrawn every cycle on the falling edge
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // hard stop in case the block hangs or loses a result
    initial begin
        #2_000_000;
        $display("FAIL morse_code_decoder");
        $finish;
    end

    // one request: optional idle cycles first, then hold valid until taken
    // entered and left on a falling edge
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            i_in_char  <= 8'($urandom_range(0, 255));
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_char  <= c;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic send_element();
        send_char($urandom_range(0, 1) ? mcd_pkg::C_IN_DASH : mcd_pkg::C_IN_DOT);
    endtask

    // one random chunk of text, mostly well-formed symbols with separators
    task automatic send_random_chunk();
        int kind;
        int sep;
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            // symbol of legal length, most of these hit the code table
            repeat ($urandom_range(1, 6))
                send_element();
            sep = $urandom_range(0, 99);
            if (sep < 62) begin
                send_char(mcd_pkg::C_IN_SPACE);
            end else if (sep < 78) begin
                send_text("  ");
            end else if (sep < 86) begin
                send_text("   ");
            end else if (sep < 94) begin
                send_char(mcd_pkg::C_IN_NEWLINE);
            end else begin
                send_text(" \n");
            end
        end else if (kind < 68) begin
            // overlong symbol
            repeat ($urandom_range(7, 9))
                send_element();
            send_char($urandom_range(0, 3) == 0 ? mcd_pkg::C_IN_NEWLINE
                                                : mcd_pkg::C_IN_SPACE);
        end else if (kind < 80) begin
            // any byte at all
            send_char(8'($urandom_range(0, 255)));
        end else if (kind < 90) begin
            // symbol broken by a stray byte
            send_element();
            send_char(8'($urandom_range(0, 255)));
            send_element();
            send_char(mcd_pkg::C_IN_SPACE);
        end else begin
            send_char($urandom_range(0, 2) == 0 ? mcd_pkg::C_IN_NEWLINE
                                                : mcd_pkg::C_IN_SPACE);
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items);
        int target;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target         = n_sent + n_items;
        while (n_sent < target)
            send_random_chunk();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_char      = 8'h00;
        i_out_ready    = 1'b1;
        n_sent         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part, no idling
        // spaces before any output and an empty symbol give nothing
        send_char(mcd_pkg::C_IN_SPACE);
        // lowest byte is an invalid element, the space then drops the symbol
        send_char(8'h00);
        send_char(mcd_pkg::C_IN_SPACE);
        // letter E, then a word space, then a third space that gives nothing
        send_text(".   ");
        // longest symbol, ended by a newline: two results
        send_text(".--.-.\n");
        // one element too many, then newline alone
        send_text(".......\n");
        // letter T, then a space straight before a newline
        send_text("- \n");
        // highest byte, then newline clears the broken symbol
        send_char(8'hFF);
        send_char(mcd_pkg::C_IN_NEWLINE);

        // random part over the idling phases
        run_phase(0, 0, 300);
        run_phase(74, 0, 300);
        run_phase(0, 74, 300);
        run_phase(8, 8, 300);

        i_in_valid     <= 1'b0;
        recv_stall_pct = 0;

        // drain, then keep running to catch any stray result
        while (n_pending != 0)
            @(negedge i_clk);
        repeat (16) @(negedge i_clk);

        if (n_fail == 0 && n_pending == 0)
            $display("PASS morse_code_decoder");
        else
            $display("FAIL morse_code_decoder");
        $finish;
    end

endmodule
